FILE: sv/sca_pkg.sv
// Shared types and constants for the sensor coalescer and advertisement encoder.
// Used by sca_ticks, sca_core and sensor_coalescer_advert_encoder_top.
`default_nettype none

package sca_pkg;

   // Request operation codes.
   typedef enum logic [2:0] {
      OP_TEMP    = 3'd0,
      OP_HUM     = 3'd1,
      OP_TICK    = 3'd2,
      OP_CO2     = 3'd3,
      OP_PAIR    = 3'd4,
      OP_PAYLOAD = 3'd5
   } op_type;

   // Result status codes.
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_REJECT  = 3'd1,
      ST_NOT_DUE = 3'd2,
      ST_NOTHING = 3'd3,
      ST_BYTE    = 3'd4
   } status_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_PROFILE   = 2'd0,
      REG_COALESCE  = 2'd1,
      REG_DEVICE_ID = 2'd2
   } reg_type;

   // One request as held in the input stage.
   typedef struct packed {
      op_type             op;
      logic signed [15:0] value_a;
      logic signed [15:0] value_b;
      logic [31:0]        now_ms;
   } item_type;

   // One result as produced for the output register.
   typedef struct packed {
      status_type  status;
      logic [7:0]  payload_byte;
      logic        complete;
      logic        last;
   } result_type;

   // Configuration write bundle.
   typedef struct packed {
      logic        write;
      logic [1:0]  index;
      logic [15:0] data;
   } csr_type;

   // Valid reading ranges in hundredths of a unit.
   localparam logic signed [15:0] TEMP_MIN = -16'sd4500;
   localparam logic signed [15:0] TEMP_MAX = 16'sd13000;
   localparam logic signed [15:0] HUM_MIN  = 16'sd0;
   localparam logic signed [15:0] HUM_MAX  = 16'sd10000;

   localparam logic [15:0] COALESCE_RESET = 16'd1000;

   // Advertisement header bytes.
   localparam logic [7:0] ADV_HDR0 = 8'hD5;
   localparam logic [7:0] ADV_HDR1 = 8'h06;
   localparam logic [7:0] ADV_HDR2 = 8'h00;
   localparam logic [7:0] ADV_HDR3 = 8'h06;

   localparam logic [3:0] BYTE_LAST = 4'd9;

   // Tick scaling: ticks = floor((n * SCALE + ROUND) / divisor), where the
   // division is an exact multiply by a rounded-up reciprocal and a shift.
   // Temperature divisor is 7000, humidity divisor is 2500.
   localparam logic signed [17:0] TEMP_OFFSET = 18'sd4500;
   localparam logic [14:0]        TEMP_SCALE  = 15'd26214;
   localparam logic [11:0]        TEMP_ROUND  = 12'd3500;
   localparam logic [29:0]        TEMP_RECIP  = 30'd628292359;
   localparam int                 TEMP_SHIFT  = 42;

   localparam logic signed [17:0] HUM_OFFSET = 18'sd600;
   localparam logic [13:0]        HUM_SCALE  = 14'd13107;
   localparam logic [10:0]        HUM_ROUND  = 11'd1250;
   localparam logic [28:0]        HUM_RECIP  = 29'd439804652;
   localparam int                 HUM_SHIFT  = 40;

   localparam logic [17:0] TICK_MAX = 18'd65535;

endpackage

`default_nettype wire

FILE: sv/sca_ticks.sv
// Converts the stored temperature and humidity samples to 16-bit ticks.
// Two register stages, one multiplier each. Depends on sca_pkg.
`default_nettype none

module sca_ticks (
   input  wire logic               clock,
   input  wire logic signed [15:0] temp_sample,
   input  wire logic signed [15:0] hum_sample,
   output logic [15:0]             temp_ticks,
   output logic [15:0]             hum_ticks
);

   logic signed [17:0] temp_off;
   logic signed [17:0] hum_off;
   logic [15:0]        temp_n;
   logic [15:0]        hum_n;
   logic [30:0]        temp_num;
   logic [29:0]        hum_num;
   logic [29:0]        temp_num_ff;
   logic [28:0]        hum_num_ff;
   logic [59:0]        temp_prod_ff;
   logic [57:0]        hum_prod_ff;
   logic [17:0]        temp_q;
   logic [17:0]        hum_q;

   // Offset the samples to the sensor scale zero, floored at zero.
   always_comb begin
      temp_off = 18'(temp_sample) + sca_pkg::TEMP_OFFSET;
      hum_off  = 18'(hum_sample) + sca_pkg::HUM_OFFSET;
      temp_n   = temp_off[17] ? 16'd0 : temp_off[15:0];
      hum_n    = hum_off[17] ? 16'd0 : hum_off[15:0];
      temp_num = 31'(temp_n) * 31'(sca_pkg::TEMP_SCALE) + 31'(sca_pkg::TEMP_ROUND);
      hum_num  = 30'(hum_n) * 30'(sca_pkg::HUM_SCALE) + 30'(sca_pkg::HUM_ROUND);
   end

   // Scaled numerators, then the reciprocal products.
   always_ff @(posedge clock) begin
      temp_num_ff  <= temp_num[29:0];
      hum_num_ff   <= hum_num[28:0];
      temp_prod_ff <= 60'(temp_num_ff) * 60'(sca_pkg::TEMP_RECIP);
      hum_prod_ff  <= 58'(hum_num_ff) * 58'(sca_pkg::HUM_RECIP);
   end

   // Quotients, clamped to the 16-bit tick range.
   always_comb begin
      temp_q     = 18'(temp_prod_ff >> sca_pkg::TEMP_SHIFT);
      hum_q      = 18'(hum_prod_ff >> sca_pkg::HUM_SHIFT);
      temp_ticks = (temp_q > sca_pkg::TICK_MAX) ? 16'hFFFF : temp_q[15:0];
      hum_ticks  = (hum_q > sca_pkg::TICK_MAX) ? 16'hFFFF : hum_q[15:0];
   end

endmodule

`default_nettype wire

FILE: sv/sca_core.sv
// Coalescer state, configuration registers and result generation.
// Depends on sca_pkg and sca_ticks.
`default_nettype none

module sca_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sca_pkg::csr_type     csr,
   input  wire sca_pkg::item_type    item,
   input  wire logic                 emit,
   output sca_pkg::result_type       result,
   output logic                      done
);

   logic               profile_ff;
   logic [15:0]        coalesce_ff;
   logic [15:0]        device_id_ff;
   logic signed [15:0] temp_sample_ff;
   logic signed [15:0] hum_sample_ff;
   logic               have_temp_ff;
   logic               have_hum_ff;
   logic               have_co2_ff;
   logic signed [15:0] pend_temp_ff;
   logic signed [15:0] pend_hum_ff;
   logic               pend_temp_flag_ff;
   logic               pend_hum_flag_ff;
   logic [31:0]        due_time_ff;
   logic [3:0]         byte_index_ff;

   logic signed [15:0] temp_sample_in;
   logic signed [15:0] hum_sample_in;
   logic               have_temp_in;
   logic               have_hum_in;
   logic               have_co2_in;
   logic               pend_temp_wr;
   logic               pend_hum_wr;
   logic               pend_temp_flag_in;
   logic               pend_hum_flag_in;
   logic [31:0]        due_time_in;
   logic [3:0]         byte_index_in;

   logic               temp_ok;
   logic               hum_ok;
   logic [31:0]        due_diff;
   logic               complete_now;
   logic               complete_next;
   sca_pkg::status_type status;
   logic [7:0]         adv_byte;
   logic [15:0]        temp_ticks;
   logic [15:0]        hum_ticks;
   logic               is_payload;

   sca_ticks u_ticks (
      .clock       (clock),
      .temp_sample (temp_sample_ff),
      .hum_sample  (hum_sample_ff),
      .temp_ticks  (temp_ticks),
      .hum_ticks   (hum_ticks)
   );

   // Range checks and the wrapping due-time compare.
   always_comb begin
      temp_ok  = (item.value_a >= sca_pkg::TEMP_MIN) && (item.value_a <= sca_pkg::TEMP_MAX);
      hum_ok   = (item.value_b >= sca_pkg::HUM_MIN) && (item.value_b <= sca_pkg::HUM_MAX);
      due_diff = item.now_ms - due_time_ff;
   end

   // Next state and status for the request in the input stage.
   always_comb begin
      temp_sample_in    = temp_sample_ff;
      hum_sample_in     = hum_sample_ff;
      have_temp_in      = have_temp_ff;
      have_hum_in       = have_hum_ff;
      have_co2_in       = have_co2_ff;
      pend_temp_wr      = 1'b0;
      pend_hum_wr       = 1'b0;
      pend_temp_flag_in = pend_temp_flag_ff;
      pend_hum_flag_in  = pend_hum_flag_ff;
      due_time_in       = due_time_ff;
      status            = sca_pkg::ST_REJECT;
      case (item.op)
         sca_pkg::OP_TEMP: begin
            if (temp_ok) begin
               pend_temp_wr      = 1'b1;
               pend_temp_flag_in = 1'b1;
               due_time_in       = item.now_ms + 32'(coalesce_ff);
               status            = sca_pkg::ST_OK;
            end else begin
               pend_temp_flag_in = 1'b0;
               pend_hum_flag_in  = 1'b0;
            end
         end
         sca_pkg::OP_HUM: begin
            if (hum_ok) begin
               pend_hum_wr      = 1'b1;
               pend_hum_flag_in = 1'b1;
               due_time_in      = item.now_ms + 32'(coalesce_ff);
               status           = sca_pkg::ST_OK;
            end else begin
               pend_temp_flag_in = 1'b0;
               pend_hum_flag_in  = 1'b0;
            end
         end
         sca_pkg::OP_TICK: begin
            if (due_diff[31]) begin
               status = sca_pkg::ST_NOT_DUE;
            end else if (!(pend_temp_flag_ff && pend_hum_flag_ff)) begin
               pend_temp_flag_in = 1'b0;
               pend_hum_flag_in  = 1'b0;
               status            = sca_pkg::ST_NOTHING;
            end else begin
               temp_sample_in    = pend_temp_ff;
               hum_sample_in     = pend_hum_ff;
               have_temp_in      = 1'b1;
               have_hum_in       = 1'b1;
               pend_temp_flag_in = 1'b0;
               pend_hum_flag_in  = 1'b0;
               status            = sca_pkg::ST_OK;
            end
         end
         sca_pkg::OP_CO2: begin
            // Only the arrival of a reading matters; its value is never reported.
            if (!profile_ff) begin
               have_co2_in = 1'b1;
               status      = sca_pkg::ST_OK;
            end
         end
         sca_pkg::OP_PAIR: begin
            if (temp_ok && hum_ok) begin
               temp_sample_in    = item.value_a;
               hum_sample_in     = item.value_b;
               have_temp_in      = 1'b1;
               have_hum_in       = 1'b1;
               pend_temp_flag_in = 1'b0;
               pend_hum_flag_in  = 1'b0;
               status            = sca_pkg::ST_OK;
            end
         end
         sca_pkg::OP_PAYLOAD: begin
            status = sca_pkg::ST_BYTE;
         end
         default: begin
            status = sca_pkg::ST_REJECT;
         end
      endcase
   end

   // Sample completeness before and after this request.
   always_comb begin
      complete_now  = have_temp_ff && have_hum_ff && (profile_ff || have_co2_ff);
      complete_next = have_temp_in && have_hum_in && (profile_ff || have_co2_in);
   end

   // Advertisement byte selected by the byte counter.
   always_comb begin
      case (byte_index_ff)
         4'd0:    adv_byte = sca_pkg::ADV_HDR0;
         4'd1:    adv_byte = sca_pkg::ADV_HDR1;
         4'd2:    adv_byte = sca_pkg::ADV_HDR2;
         4'd3:    adv_byte = sca_pkg::ADV_HDR3;
         4'd4:    adv_byte = device_id_ff[7:0];
         4'd5:    adv_byte = device_id_ff[15:8];
         4'd6:    adv_byte = temp_ticks[7:0];
         4'd7:    adv_byte = temp_ticks[15:8];
         4'd8:    adv_byte = hum_ticks[7:0];
         4'd9:    adv_byte = hum_ticks[15:8];
         default: adv_byte = 8'd0;
      endcase
   end

   // Result for the output register; a payload request yields ten of them.
   always_comb begin
      is_payload    = (item.op == sca_pkg::OP_PAYLOAD);
      done          = !is_payload || (byte_index_ff == sca_pkg::BYTE_LAST);
      byte_index_in = done ? 4'd0 : byte_index_ff + 4'd1;
      result.status = status;
      if (is_payload) begin
         result.payload_byte = (profile_ff && complete_now) ? adv_byte : 8'd0;
         result.complete     = complete_now;
         result.last         = (byte_index_ff == sca_pkg::BYTE_LAST);
      end else begin
         result.payload_byte = 8'd0;
         result.complete     = complete_next;
         result.last         = 1'b1;
      end
   end

   // Pending values have no reset; they are read only while their flag is set.
   always_ff @(posedge clock) begin
      if (emit && pend_temp_wr) begin
         pend_temp_ff <= item.value_a;
      end
      if (emit && pend_hum_wr) begin
         pend_hum_ff <= item.value_b;
      end
   end

   // State and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         profile_ff        <= 1'b0;
         coalesce_ff       <= sca_pkg::COALESCE_RESET;
         device_id_ff      <= 16'd0;
         temp_sample_ff    <= 16'sd0;
         hum_sample_ff     <= 16'sd0;
         have_temp_ff      <= 1'b0;
         have_hum_ff       <= 1'b0;
         have_co2_ff       <= 1'b0;
         pend_temp_flag_ff <= 1'b0;
         pend_hum_flag_ff  <= 1'b0;
         due_time_ff       <= 32'd0;
         byte_index_ff     <= 4'd0;
      end else begin
         if (emit) begin
            temp_sample_ff    <= temp_sample_in;
            hum_sample_ff     <= hum_sample_in;
            have_temp_ff      <= have_temp_in;
            have_hum_ff       <= have_hum_in;
            have_co2_ff       <= have_co2_in;
            pend_temp_flag_ff <= pend_temp_flag_in;
            pend_hum_flag_ff  <= pend_hum_flag_in;
            due_time_ff       <= due_time_in;
            byte_index_ff     <= byte_index_in;
         end
         if (csr.write) begin
            case (sca_pkg::reg_type'(csr.index))
               sca_pkg::REG_PROFILE: begin
                  profile_ff <= csr.data[0];
                  if (csr.data[0]) begin
                     have_co2_ff <= 1'b0;
                  end
               end
               sca_pkg::REG_COALESCE:  coalesce_ff  <= csr.data;
               sca_pkg::REG_DEVICE_ID: device_id_ff <= csr.data;
               default: ;
            endcase
         end
      end
   end

endmodule

`default_nettype wire

FILE: sv/sensor_coalescer_advert_encoder_top.sv
// Sensor event coalescer and advertisement encoder. A request is taken into an
// input register and resolved combinationally into a result register, so one
// request per cycle is accepted while the output is free. Each request gives
// one result, except a payload request, which gives ten byte results and holds
// the input stage until its last byte is loaded. Tick values for the payload
// come from a two-stage multiplier pipeline that follows the stored sample, so
// payload bytes always reflect the sample as committed by the requests before.
// Configuration writes are taken at any time but should only be made while no
// request is in flight. Depends on sca_pkg and sca_core.
`default_nettype none

module sensor_coalescer_advert_encoder_top (
   input  wire logic               clock,
   input  wire logic               reset,
   // Request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_op,
   input  wire logic signed [15:0] req_value_a,
   input  wire logic signed [15:0] req_value_b,
   input  wire logic [15:0]        req_co2_ppm,
   input  wire logic [31:0]        req_now_ms,
   // Result channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [7:0]              rsp_payload_byte,
   output logic                    rsp_sample_ready,
   output logic                    rsp_last,
   // Configuration port
   input  wire logic               csr_write,
   input  wire logic [1:0]         csr_index,
   input  wire logic [15:0]        csr_data
);

   logic                 in_valid_ff;
   sca_pkg::item_type    item_ff;
   logic                 out_valid_ff;
   sca_pkg::result_type  out_ff;
   logic                 accept;
   logic                 emit;
   logic                 done;
   sca_pkg::result_type  result;
   sca_pkg::csr_type     csr;

   // Handshake: a result moves out when the output register is free or drains.
   always_comb begin
      emit      = in_valid_ff && (!out_valid_ff || !rsp_stall);
      req_stall = in_valid_ff && !(emit && done);
      accept    = req_valid && !req_stall;
      csr.write = csr_write;
      csr.index = csr_index;
      csr.data  = csr_data;
   end

   sca_core u_core (
      .clock  (clock),
      .reset  (reset),
      .csr    (csr),
      .item   (item_ff),
      .emit   (emit),
      .result (result),
      .done   (done)
   );

   // Input stage. The CO2 value itself is never reported, so it is not kept.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (emit && done) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.op      <= sca_pkg::op_type'(req_op);
         item_ff.value_a <= req_value_a;
         item_ff.value_b <= req_value_b;
         item_ff.now_ms  <= req_now_ms;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_ff.status;
   assign rsp_payload_byte = out_ff.payload_byte;
   assign rsp_sample_ready = out_ff.complete;
   assign rsp_last         = out_ff.last;

   // An empty input stage never holds off a new request.
   a_empty_no_stall: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> !req_stall)
      else $error("input stage empty but request stalled");

   // The last flag of a result marks exactly the end of the request.
   a_last_matches_done: assert property (@(posedge clock) disable iff (reset)
      emit |-> (result.last == done))
      else $error("last flag disagrees with request completion");

   // A payload byte that is not the last keeps the payload request in place.
   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      (emit && (result.status == sca_pkg::ST_BYTE) && !result.last)
      |=> (in_valid_ff && (item_ff.op == sca_pkg::OP_PAYLOAD)))
      else $error("payload request left before its last byte");

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Testbench for sensor_coalescer_advert_encoder_top: directed and random requests are
// checked against a behavioral predictor of the coalescer and advertisement encoder.
// Depends on sca_pkg and the RTL of sensor_coalescer_advert_encoder_top.
`timescale 1ns / 100ps

module testbench;

   localparam int QUIET_LIMIT = 2000;

   // Expected contents of one result.
   typedef struct {
      sca_pkg::status_type status;
      logic [7:0]          payload;
      logic                complete;
      logic                last;
   } advert_result_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [2:0]         req_op;
   logic signed [15:0] req_value_a;
   logic signed [15:0] req_value_b;
   logic [15:0]        req_co2_ppm;
   logic [31:0]        req_now_ms;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [2:0]         rsp_status;
   logic [7:0]         rsp_payload_byte;
   logic               rsp_sample_ready;
   logic               rsp_last;
   logic               csr_write;
   logic [1:0]         csr_index;
   logic [15:0]        csr_data;

   // Predicted configuration and sensor state.
   logic               cfg_profile   = 1'b0;
   logic [15:0]        cfg_coalesce  = 16'd1000;
   logic [15:0]        cfg_device    = 16'd0;
   logic signed [15:0] stored_temp   = '0;
   logic signed [15:0] stored_hum    = '0;
   logic               temp_valid    = 1'b0;
   logic               hum_valid     = 1'b0;
   logic               co2_valid     = 1'b0;
   logic signed [15:0] held_temp     = '0;
   logic signed [15:0] held_hum      = '0;
   logic               held_temp_set = 1'b0;
   logic               held_hum_set  = 1'b0;
   logic [31:0]        deadline      = '0;

   advert_result_type expected_results[$];
   int failures     = 0;
   int sent_count   = 0;
   int req_gap_max  = 14;
   int rsp_gap_max  = 14;
   int hold_len     = 0;
   int quiet_cycles = 0;
   logic [31:0] clock_ms;

   sensor_coalescer_advert_encoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_value_a      (req_value_a),
      .req_value_b      (req_value_b),
      .req_co2_ppm      (req_co2_ppm),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_sample_ready (rsp_sample_ready),
      .rsp_last         (rsp_last),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #2 clock = ~clock;

   // Random 16-bit field value.
   function automatic logic [15:0] rand16();
      return 16'($urandom);
   endfunction

   // The stored sample is complete when every reading of the profile is present.
   function automatic logic sample_full_now();
      return temp_valid && hum_valid && (cfg_profile || co2_valid);
   endfunction

   // Scales an offset reading to 0..65535 ticks, rounding half up.
   function automatic logic [15:0] scale_ticks(input int n, input longint span);
      longint q;
      if (n <= 0) return 16'd0;
      q = (longint'(n) * 131070 + span) / (2 * span);
      return (q > 65535) ? 16'hFFFF : q[15:0];
   endfunction

   // Updates the predicted state for one accepted request and queues its results.
   task automatic predict_request(input logic [2:0] op, input logic signed [15:0] a,
                                  input logic signed [15:0] b, input logic [31:0] now);
      advert_result_type   r;
      logic [7:0]          adv [10];
      logic [15:0]         t_ticks;
      logic [15:0]         h_ticks;
      logic [31:0]         since_due;
      logic                temp_in;
      logic                hum_in;
      logic                full;
      sca_pkg::status_type st;
      temp_in = (a >= -16'sd4500) && (a <= 16'sd13000);
      hum_in  = (b >= 16'sd0) && (b <= 16'sd10000);
      st = sca_pkg::ST_REJECT;
      if (op == sca_pkg::OP_PAYLOAD) begin
         full    = sample_full_now();
         t_ticks = scale_ticks(int'(stored_temp) + 4500, 17500);
         h_ticks = scale_ticks(int'(stored_hum) + 600, 12500);
         adv = '{8'hD5, 8'h06, 8'h00, 8'h06, cfg_device[7:0], cfg_device[15:8],
                 t_ticks[7:0], t_ticks[15:8], h_ticks[7:0], h_ticks[15:8]};
         for (int k = 0; k < 10; k++) begin
            r.status   = sca_pkg::ST_BYTE;
            r.payload  = (cfg_profile && full) ? adv[k] : 8'h00;
            r.complete = full;
            r.last     = (k == 9);
            expected_results.push_back(r);
         end
      end else begin
         case (op)
            sca_pkg::OP_TEMP: begin
               if (!temp_in) begin
                  held_temp_set = 1'b0;
                  held_hum_set  = 1'b0;
               end else begin
                  held_temp     = a;
                  held_temp_set = 1'b1;
                  deadline      = now + 32'(cfg_coalesce);
                  st            = sca_pkg::ST_OK;
               end
            end
            sca_pkg::OP_HUM: begin
               if (!hum_in) begin
                  held_temp_set = 1'b0;
                  held_hum_set  = 1'b0;
               end else begin
                  held_hum     = b;
                  held_hum_set = 1'b1;
                  deadline     = now + 32'(cfg_coalesce);
                  st           = sca_pkg::ST_OK;
               end
            end
            sca_pkg::OP_TICK: begin
               since_due = now - deadline;
               if (since_due[31]) begin
                  st = sca_pkg::ST_NOT_DUE;
               end else if (!(held_temp_set && held_hum_set)) begin
                  held_temp_set = 1'b0;
                  held_hum_set  = 1'b0;
                  st = sca_pkg::ST_NOTHING;
               end else begin
                  stored_temp   = held_temp;
                  stored_hum    = held_hum;
                  temp_valid    = 1'b1;
                  hum_valid     = 1'b1;
                  held_temp_set = 1'b0;
                  held_hum_set  = 1'b0;
                  st = sca_pkg::ST_OK;
               end
            end
            sca_pkg::OP_CO2: begin
               if (!cfg_profile) begin
                  co2_valid = 1'b1;
                  st = sca_pkg::ST_OK;
               end
            end
            sca_pkg::OP_PAIR: begin
               if (temp_in && hum_in) begin
                  stored_temp   = a;
                  stored_hum    = b;
                  temp_valid    = 1'b1;
                  hum_valid     = 1'b1;
                  held_temp_set = 1'b0;
                  held_hum_set  = 1'b0;
                  st = sca_pkg::ST_OK;
               end
            end
            default: st = sca_pkg::ST_REJECT;
         endcase
         r.status   = st;
         r.payload  = 8'h00;
         r.complete = sample_full_now();
         r.last     = 1'b1;
         expected_results.push_back(r);
      end
   endtask

   // Offers one request, waits for it to be taken, then idles for a random gap.
   task automatic send_request(input logic [2:0] op, input logic [15:0] a,
                               input logic [15:0] b, input logic [15:0] co2,
                               input logic [31:0] now);
      int gap;
      req_valid   <= 1'b1;
      req_op      <= op;
      req_value_a <= a;
      req_value_b <= b;
      req_co2_ppm <= co2;
      req_now_ms  <= now;
      do @(posedge clock); while (req_stall !== 1'b0);
      predict_request(op, a, b, now);
      sent_count++;
      gap = int'($urandom_range(0, req_gap_max));
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stops offering requests and lets every expected result come out.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes one configuration register; only called while the block is idle.
   task automatic write_reg(input sca_pkg::reg_type idx, input logic [15:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         sca_pkg::REG_PROFILE: begin
            cfg_profile = data[0];
            if (data[0]) co2_valid = 1'b0;
         end
         sca_pkg::REG_COALESCE:  cfg_coalesce = data;
         sca_pkg::REG_DEVICE_ID: cfg_device   = data;
         default: ;
      endcase
   endtask

   // Reset state: empty payload, nothing to commit, unused operation codes.
   task automatic test_power_on();
      send_request(sca_pkg::OP_PAYLOAD, rand16(), rand16(), rand16(), $urandom);
      send_request(sca_pkg::OP_TICK, rand16(), rand16(), rand16(), 32'd0);
      send_request(3'd6, rand16(), rand16(), rand16(), $urandom);
      send_request(3'd7, rand16(), rand16(), rand16(), $urandom);
   endtask

   // Range limits of separate readings, the due check and a due time that wraps past zero.
   task automatic test_coalescing();
      drain_results();
      write_reg(sca_pkg::REG_PROFILE, 16'd1);
      write_reg(sca_pkg::REG_DEVICE_ID, 16'h5AA5);
      send_request(sca_pkg::OP_TEMP, -16'sd4501, rand16(), rand16(), 32'd10);
      send_request(sca_pkg::OP_TEMP, 16'sd13001, rand16(), rand16(), 32'd20);
      send_request(sca_pkg::OP_HUM, rand16(), -16'sd1, rand16(), 32'd30);
      send_request(sca_pkg::OP_HUM, rand16(), 16'sd10001, rand16(), 32'd40);
      send_request(sca_pkg::OP_TEMP, -16'sd4500, rand16(), rand16(), 32'd100);
      send_request(sca_pkg::OP_HUM, rand16(), 16'sd10000, rand16(), 32'd200);
      send_request(sca_pkg::OP_TICK, rand16(), rand16(), rand16(), 32'd1199);
      send_request(sca_pkg::OP_TICK, rand16(), rand16(), rand16(), 32'd1200);
      send_request(sca_pkg::OP_PAYLOAD, rand16(), rand16(), rand16(), $urandom);
      // The due time wraps past zero; only the temperature is pending.
      send_request(sca_pkg::OP_TEMP, 16'sd13000, rand16(), rand16(), 32'hFFFF_FE00);
      send_request(sca_pkg::OP_TICK, rand16(), rand16(), rand16(), 32'hFFFF_FFFF);
      send_request(sca_pkg::OP_TICK, rand16(), rand16(), rand16(), 32'h0000_01E8);
   endtask

   // Direct pairs at the range limits and a CO2 reading outside its profile.
   task automatic test_direct_pair();
      send_request(sca_pkg::OP_PAIR, 16'sd13000, 16'sd10000, rand16(), $urandom);
      send_request(sca_pkg::OP_PAIR, 16'sd13001, 16'sd0, rand16(), $urandom);
      send_request(sca_pkg::OP_CO2, rand16(), rand16(), 16'hFFFF, $urandom);
      send_request(sca_pkg::OP_PAYLOAD, rand16(), rand16(), rand16(), $urandom);
   endtask

   // In the CO2 profile the sample needs a CO2 reading and the payload stays zero.
   task automatic test_co2_profile();
      drain_results();
      write_reg(sca_pkg::REG_PROFILE, 16'd0);
      send_request(sca_pkg::OP_CO2, rand16(), rand16(), 16'h0000, $urandom);
      send_request(sca_pkg::OP_PAYLOAD, rand16(), rand16(), rand16(), $urandom);
   endtask

   // With no coalescing delay a tick at the reading time already commits.
   task automatic test_zero_delay();
      logic [31:0] at;
      at = $urandom;
      drain_results();
      write_reg(sca_pkg::REG_PROFILE, 16'd1);
      write_reg(sca_pkg::REG_COALESCE, 16'd0);
      write_reg(sca_pkg::REG_DEVICE_ID, 16'hFFFF);
      send_request(sca_pkg::OP_TEMP, -16'sd4500, rand16(), rand16(), at);
      send_request(sca_pkg::OP_HUM, rand16(), 16'sd0, rand16(), at);
      send_request(sca_pkg::OP_TICK, rand16(), rand16(), rand16(), at - 32'd1);
      send_request(sca_pkg::OP_TICK, rand16(), rand16(), rand16(), at);
      send_request(sca_pkg::OP_PAYLOAD, rand16(), rand16(), rand16(), $urandom);
   endtask

   // Random traffic in four configurations; reading-and-tick sequences are the most frequent kind.
   task automatic test_random_traffic();
      logic [15:0]        delays  [4];
      logic [15:0]        devices [4];
      logic signed [15:0] bad;
      int                 p;
      int                 kind;
      int                 target;
      int                 shape;
      int                 good_temp;
      int                 good_hum;
      logic               hum_first;
      delays  = '{16'd0, 16'd65535, 16'd1000, 16'd37};
      devices = '{16'hFFFF, 16'h0000, 16'h0000, 16'h1234};
      for (p = 0; p < 4; p++) begin
         drain_results();
         write_reg(sca_pkg::REG_PROFILE, (p == 1) ? 16'd0 : 16'd1);
         write_reg(sca_pkg::REG_COALESCE, (p == 3) ? rand16() : delays[p]);
         write_reg(sca_pkg::REG_DEVICE_ID, (p == 1 || p == 3) ? rand16() : devices[p]);
         req_gap_max = (p == 2) ? 0 : 14;
         rsp_gap_max = (p == 2) ? 0 : 14;
         clock_ms = $urandom;
         target = sent_count + 20;
         while (sent_count < target) begin
            kind = int'($urandom_range(0, 9));
            if (kind <= 3) begin
               // Separate readings, then maybe a tick before the due time and one at or after it.
               good_temp = int'($urandom_range(0, 17500)) - 4500;
               good_hum  = int'($urandom_range(0, 10000));
               hum_first = 1'($urandom_range(0, 1));
               shape     = int'($urandom_range(0, 7));
               clock_ms  = clock_ms + $urandom_range(0, 500);
               if (hum_first)
                  send_request(sca_pkg::OP_HUM, rand16(), 16'(good_hum), rand16(), clock_ms);
               else
                  send_request(sca_pkg::OP_TEMP, 16'(good_temp), rand16(), rand16(), clock_ms);
               clock_ms = clock_ms + $urandom_range(0, 500);
               if (shape == 1) begin
                  if (hum_first) begin
                     do bad = 16'($urandom); while (bad >= -16'sd4500 && bad <= 16'sd13000);
                     send_request(sca_pkg::OP_TEMP, bad, rand16(), rand16(), clock_ms);
                  end else begin
                     do bad = 16'($urandom); while (bad >= 16'sd0 && bad <= 16'sd10000);
                     send_request(sca_pkg::OP_HUM, rand16(), bad, rand16(), clock_ms);
                  end
               end else if (shape != 0) begin
                  if (hum_first)
                     send_request(sca_pkg::OP_TEMP, 16'(good_temp), rand16(), rand16(),
                                  clock_ms);
                  else
                     send_request(sca_pkg::OP_HUM, rand16(), 16'(good_hum), rand16(),
                                  clock_ms);
               end
               if ($urandom_range(0, 1) != 0 && cfg_coalesce != 0)
                  send_request(sca_pkg::OP_TICK, rand16(), rand16(), rand16(),
                               deadline - $urandom_range(1, cfg_coalesce));
               clock_ms = deadline + $urandom_range(0, 300);
               send_request(sca_pkg::OP_TICK, rand16(), rand16(), rand16(), clock_ms);
            end else if (kind == 4) begin
               if ($urandom_range(0, 4) == 0)
                  send_request(sca_pkg::OP_PAIR, rand16(), rand16(), rand16(), $urandom);
               else
                  send_request(sca_pkg::OP_PAIR,
                               16'(int'($urandom_range(0, 17500)) - 4500),
                               16'($urandom_range(0, 10000)), rand16(), $urandom);
            end else if (kind == 5) begin
               send_request(sca_pkg::OP_PAYLOAD, rand16(), rand16(), rand16(), $urandom);
            end else if (kind == 6) begin
               send_request(sca_pkg::OP_CO2, rand16(), rand16(), rand16(), $urandom);
            end else if (kind == 7) begin
               send_request(sca_pkg::OP_TICK, rand16(), rand16(), rand16(),
                            deadline + $urandom_range(0, 4000) - 32'd2000);
            end else begin
               send_request(3'($urandom_range(0, 7)), rand16(), rand16(), rand16(),
                            $urandom);
            end
         end
      end
   endtask

   // The result side holds off for a long stretch while requests keep coming.
   task automatic test_backpressure();
      drain_results();
      write_reg(sca_pkg::REG_PROFILE, 16'd1);
      req_gap_max = 0;
      hold_len = 300;
      for (int i = 0; i < 16; i++) begin
         if (i % 3 == 0)
            send_request(sca_pkg::OP_PAYLOAD, rand16(), rand16(), rand16(), $urandom);
         else
            send_request(sca_pkg::OP_PAIR, 16'(int'($urandom_range(0, 17500)) - 4500),
                         16'($urandom_range(0, 10000)), rand16(), $urandom);
      end
      req_gap_max = 14;
   endtask

   // Result side: random stalls per result, or a long hold when one is requested.
   initial begin : result_drain
      int n;
      forever begin
         if (hold_len != 0) begin
            n = hold_len;
            hold_len = 0;
         end else begin
            n = int'($urandom_range(0, rsp_gap_max));
         end
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Compares every accepted result with the oldest expectation.
   always @(posedge clock) begin : result_check
      advert_result_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: status %0d, byte %0h", rsp_status, rsp_payload_byte);
            failures++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_payload_byte !== want.payload) begin
               $error("payload_byte: expected %0h, got %0h", want.payload, rsp_payload_byte);
               failures++;
            end
            if (rsp_sample_ready !== want.complete) begin
               $error("sample_ready: expected %0b, got %0b", want.complete,
                      rsp_sample_ready);
               failures++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               failures++;
            end
         end
      end
   end

   // Ends the run when neither channel has moved for too long.
   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_stall === 1'b0) ||
          (rsp_valid === 1'b1 && rsp_stall === 1'b0))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[sensor_coalescer_advert_encoder_top] ERROR");
         $finish;
      end
   end

   // Test sequence.
   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_op      <= sca_pkg::OP_TEMP;
      req_value_a <= '0;
      req_value_b <= '0;
      req_co2_ppm <= '0;
      req_now_ms  <= '0;
      csr_write   <= 1'b0;
      csr_index   <= sca_pkg::REG_PROFILE;
      csr_data    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_power_on();
      test_coalescing();
      test_direct_pair();
      test_co2_profile();
      test_zero_delay();
      test_random_traffic();
      test_backpressure();
      drain_results();
      repeat (20) @(posedge clock);
      if (failures == 0 && expected_results.size() == 0)
         $display("[sensor_coalescer_advert_encoder_top] OK");
      else
         $display("[sensor_coalescer_advert_encoder_top] ERROR");
      $finish;
   end

endmodule

FILE: files.f
sv/sca_pkg.sv
sv/sca_ticks.sv
sv/sca_core.sv
sv/sensor_coalescer_advert_encoder_top.sv
verif/testbench.sv
